FILE: rtl/dtpbs_pkg.sv
// shared types and constants for the drop-tail packet buffer scheduler
// no dependencies

package dtpbs_pkg;

    localparam int TIME_W       = 32;
    localparam int PROC_W       = 16;
    localparam int BUF_SIZE_W   = 7;
    localparam int DEPTH_DEF    = 64;

    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RST = 7'd64;

    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [PROC_W-1:0]     t_proc;
    typedef logic [BUF_SIZE_W-1:0] t_buf_size;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // every cell takes its upstream neighbour's contents
        logic append;  // the first empty cell loads the new finish time
    } t_cell_ctl;

endpackage

FILE: rtl/dtpbs_cell.sv
// one storage cell of the finish-time chain
// depends on dtpbs_pkg

module dtpbs_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtpbs_pkg::t_cell_ctl i_ctl,
    input  logic              i_prev_valid,
    input  logic              i_next_valid,
    input  dtpbs_pkg::t_time  i_next_data,
    input  dtpbs_pkg::t_time  i_new_data,
    output logic              o_valid,
    output dtpbs_pkg::t_time  o_data
);
    import dtpbs_pkg::*;

    logic  r_valid;
    t_time r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.append && i_prev_valid && !r_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_next_data;
        end else if (i_ctl.append && i_prev_valid && !r_valid) begin
            r_data <= i_new_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/drop_tail_packet_buffer_scheduler_unit.sv
// top level of the drop-tail packet buffer scheduler: sequencer and cell chain
// depends on dtpbs_pkg and dtpbs_cell
//
// channel   | direction | handshake                | word
// ----------+-----------+--------------------------+------------------------------
// packet    | in        | start high, busy low     | i_arrival_time, i_process_time
// result    | out       | o_res_strobe, one cycle  | o_dropped, o_start_time
// config    | in        | i_cfg_valid, o_cfg_ready | i_cfg_data (buffer size)
//
// a packet first retires each buffered packet that finished by its arrival, then is decided;
// retirement shifts the whole cell chain by one place per cycle
// the result strobe rises the cycle after the decision, while busy is already low
// synchronous active-low reset empties the chain and sets the buffer size to 64
// the receiver cannot stall; config writes are always taken (ready tied high)

module drop_tail_packet_buffer_scheduler_unit #(
    parameter int DEPTH = dtpbs_pkg::DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  dtpbs_pkg::t_time       i_arrival_time,
    input  dtpbs_pkg::t_proc       i_process_time,
    output logic                   o_res_strobe,
    output logic                   o_dropped,
    output dtpbs_pkg::t_time       o_start_time,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  dtpbs_pkg::t_buf_size   i_cfg_data
);
    import dtpbs_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > BUF_SIZE_W) ? OCC_W : BUF_SIZE_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    // sequencer state
    logic              r_state, n_state;
    logic [OCC_W-1:0]  r_occ, n_occ;
    t_buf_size         r_buf_size;

    // latched packet word and newest finish time
    t_time             r_arrival;
    t_proc             r_proc;
    t_time             r_tail, n_tail;

    // result register
    logic              r_strobe, n_strobe;
    logic              r_dropped, n_dropped;
    t_time             r_start, n_start;

    // chain wiring
    logic              w_valid [DEPTH];
    t_time             w_data  [DEPTH];
    t_cell_ctl         w_ctl;

    logic              w_retire;
    logic              w_full;
    logic [CMP_W-1:0]  w_limit;
    logic [CMP_W-1:0]  w_buf_ext;
    t_time             w_start;
    logic [TIME_W:0]   w_sum;
    t_time             w_finish;

    assign busy        = (r_state == ST_WORK);
    assign o_cfg_ready = 1'b1;

    // buffer size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size <= BUF_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_buf_size <= i_cfg_data;
        end
    end

    // effective limit saturates at the chain length
    assign w_buf_ext = CMP_W'(r_buf_size);
    assign w_limit   = (w_buf_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : w_buf_ext;
    assign w_full    = (CMP_W'(r_occ) >= w_limit);

    // head cell finished at or before this arrival
    assign w_retire  = w_valid[0] && (w_data[0] <= r_arrival);

    // start after the newest buffered packet, or on arrival when empty
    assign w_start   = w_valid[0] ? r_tail : r_arrival;
    assign w_sum     = {1'b0, w_start} + (TIME_W+1)'(r_proc);
    assign w_finish  = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_tail       = r_tail;
        n_strobe     = 1'b0;
        n_dropped    = r_dropped;
        n_start      = r_start;
        w_ctl.shift  = 1'b0;
        w_ctl.append = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK: begin
                priority if (w_retire) begin
                    // retire the oldest packet, chain moves one place
                    w_ctl.shift = 1'b1;
                    n_occ       = r_occ - OCC_W'(1);
                end else if (w_full) begin
                    n_state   = ST_IDLE;
                    n_strobe  = 1'b1;
                    n_dropped = 1'b1;
                    n_start   = r_arrival;
                end else begin
                    w_ctl.append = 1'b1;
                    n_occ        = r_occ + OCC_W'(1);
                    n_tail       = w_finish;
                    n_state      = ST_IDLE;
                    n_strobe     = 1'b1;
                    n_dropped    = 1'b0;
                    n_start      = w_start;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_arrival <= i_arrival_time;
            r_proc    <= i_process_time;
        end
        r_tail    <= n_tail;
        r_dropped <= n_dropped;
        r_start   <= n_start;
    end

    assign o_res_strobe = r_strobe;
    assign o_dropped    = r_dropped;
    assign o_start_time = r_start;

    // cell 0 is the oldest packet; data moves towards it on retirement
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic  w_prev_valid;
        logic  w_next_valid;
        t_time w_next_data;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_data  = w_data[g+1];
        end

        dtpbs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .i_new_data   (w_finish),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g])
        );
    end

endmodule
